// ===== design/clmu_pkg.sv =====
// Package for the load/move unit: access codes, command codes, opcode constants.
// Used by every module of the block; depends on nothing.
package clmu_pkg;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_WRITE = 2'd2;

    localparam logic CMD_INSTR = 1'b0;
    localparam logic CMD_RDATA = 1'b1;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    localparam logic [2:0] RCODE_MEM = 3'd6;
    localparam logic [2:0] RCODE_A   = 3'd7;

    localparam logic [7:0] OP_HALT    = 8'h76;
    localparam logic [7:0] OP_LD_BC   = 8'h01;
    localparam logic [7:0] OP_LD_DE   = 8'h11;
    localparam logic [7:0] OP_LD_HL   = 8'h21;
    localparam logic [7:0] OP_LD_SP   = 8'h31;
    localparam logic [7:0] OP_LD_B_N  = 8'h06;
    localparam logic [7:0] OP_LD_C_N  = 8'h0E;
    localparam logic [7:0] OP_LD_D_N  = 8'h16;
    localparam logic [7:0] OP_LD_E_N  = 8'h1E;
    localparam logic [7:0] OP_LD_H_N  = 8'h26;
    localparam logic [7:0] OP_LD_L_N  = 8'h2E;
    localparam logic [7:0] OP_LD_A_N  = 8'h3E;
    localparam logic [7:0] OP_ST_HL_N = 8'h36;
    localparam logic [7:0] OP_ST_BC   = 8'h02;
    localparam logic [7:0] OP_ST_DE   = 8'h12;
    localparam logic [7:0] OP_ST_HLI  = 8'h22;
    localparam logic [7:0] OP_ST_HLD  = 8'h32;
    localparam logic [7:0] OP_LD_BC_M = 8'h0A;
    localparam logic [7:0] OP_LD_DE_M = 8'h1A;
    localparam logic [7:0] OP_LD_HLI  = 8'h2A;
    localparam logic [7:0] OP_LD_HLD  = 8'h3A;
    localparam logic [7:0] OP_STH_N   = 8'hE0;
    localparam logic [7:0] OP_LDH_N   = 8'hF0;
    localparam logic [7:0] OP_STH_C   = 8'hE2;
    localparam logic [7:0] OP_LDH_C   = 8'hF2;
    localparam logic [7:0] OP_ST_ABS  = 8'hEA;
    localparam logic [7:0] OP_LD_ABS  = 8'hFA;
    localparam logic [7:0] OP_SP_HL   = 8'hF9;
    localparam logic [7:0] OP_HL_SPE  = 8'hF8;
    localparam logic [7:0] OP_ST_SP   = 8'h08;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
        logic [7:0]  accum;
        logic [15:0] pointer;
        logic [15:0] stack;
        logic [3:0]  flags;
    } result_t;

endpackage

// ===== design/clmu_exec.sv =====
// Execution core: architectural state and the single-pass decode of one item.
// Depends on clmu_pkg.
module clmu_exec
    import clmu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       cmd,
    input  logic [7:0] opcode,
    input  logic [7:0] imm_low,
    input  logic [7:0] imm_high,
    input  logic [7:0] read_data,
    output result_t    res_first,
    output result_t    res_second,
    output logic       two_results
);

    logic [7:0]  regs_reg [7];
    logic [7:0]  regs_next [7];
    logic [15:0] sp_reg, sp_next;
    logic [3:0]  flags_reg, flags_next;
    logic        pend_reg, pend_next;
    logic [2:0]  dest_reg, dest_next;

    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] hl, bc, de, imm16, sum16;
    logic [4:0]  sum_nib;
    logic [8:0]  sum_byte;
    logic [2:0]  dst, src;

    function automatic logic [2:0] slot(input logic [2:0] code);
        return (code == RCODE_A) ? 3'd6 : code;
    endfunction

    always_comb
    begin
        hl    = {regs_reg[4], regs_reg[5]};
        bc    = {regs_reg[0], regs_reg[1]};
        de    = {regs_reg[2], regs_reg[3]};
        imm16 = {imm_high, imm_low};
        dst   = opcode[5:3];
        src   = opcode[2:0];
        sum16    = sp_reg + {{8{imm_low[7]}}, imm_low};
        sum_nib  = {1'b0, sp_reg[3:0]} + {1'b0, imm_low[3:0]};
        sum_byte = {1'b0, sp_reg[7:0]} + {1'b0, imm_low};
        regs_next  = regs_reg;
        sp_next    = sp_reg;
        flags_next = flags_reg;
        pend_next  = 1'b0;
        dest_next  = dest_reg;
        kind = ACC_NONE;
        addr = '0;
        data = '0;
        two_results = 1'b0;
        if (cmd == CMD_RDATA)
        begin
            if (pend_reg && dest_reg != RCODE_MEM)
            begin
                regs_next[slot(dest_reg)] = read_data;
            end
        end
        else if (opcode[7:6] == 2'b01)
        begin
            if (opcode == OP_HALT)
            begin
                kind = ACC_NONE;
            end
            else if (src == RCODE_MEM)
            begin
                kind = ACC_READ; addr = hl; pend_next = 1'b1; dest_next = dst;
            end
            else if (dst == RCODE_MEM)
            begin
                kind = ACC_WRITE; addr = hl; data = regs_reg[slot(src)];
            end
            else
            begin
                regs_next[slot(dst)] = regs_reg[slot(src)];
            end
        end
        else
        begin
            case (opcode)
                OP_LD_BC: begin regs_next[0] = imm_high; regs_next[1] = imm_low; end
                OP_LD_DE: begin regs_next[2] = imm_high; regs_next[3] = imm_low; end
                OP_LD_HL: begin regs_next[4] = imm_high; regs_next[5] = imm_low; end
                OP_LD_SP: sp_next = imm16;
                OP_LD_B_N, OP_LD_C_N, OP_LD_D_N, OP_LD_E_N,
                OP_LD_H_N, OP_LD_L_N, OP_LD_A_N:
                    regs_next[slot(dst)] = imm_low;
                OP_ST_HL_N: begin kind = ACC_WRITE; addr = hl; data = imm_low; end
                OP_ST_BC: begin kind = ACC_WRITE; addr = bc; data = regs_reg[6]; end
                OP_ST_DE: begin kind = ACC_WRITE; addr = de; data = regs_reg[6]; end
                OP_ST_HLI, OP_ST_HLD:
                begin
                    kind = ACC_WRITE; addr = hl; data = regs_reg[6];
                    {regs_next[4], regs_next[5]} = (opcode == OP_ST_HLI) ? hl + 16'd1
                                                                        : hl - 16'd1;
                end
                OP_LD_BC_M, OP_LD_DE_M, OP_LD_HLI, OP_LD_HLD, OP_LDH_N, OP_LDH_C,
                OP_LD_ABS:
                begin
                    kind = ACC_READ; pend_next = 1'b1; dest_next = RCODE_A;
                    case (opcode)
                        OP_LD_BC_M: addr = bc;
                        OP_LD_DE_M: addr = de;
                        OP_LDH_N:   addr = HIGH_PAGE | {8'h00, imm_low};
                        OP_LDH_C:   addr = HIGH_PAGE | {8'h00, regs_reg[1]};
                        OP_LD_ABS:  addr = imm16;
                        default:    addr = hl;
                    endcase
                    if (opcode == OP_LD_HLI)
                    begin
                        {regs_next[4], regs_next[5]} = hl + 16'd1;
                    end
                    if (opcode == OP_LD_HLD)
                    begin
                        {regs_next[4], regs_next[5]} = hl - 16'd1;
                    end
                end
                OP_STH_N:
                begin
                    kind = ACC_WRITE; addr = HIGH_PAGE | {8'h00, imm_low}; data = regs_reg[6];
                end
                OP_STH_C:
                begin
                    kind = ACC_WRITE; addr = HIGH_PAGE | {8'h00, regs_reg[1]};
                    data = regs_reg[6];
                end
                OP_ST_ABS: begin kind = ACC_WRITE; addr = imm16; data = regs_reg[6]; end
                OP_SP_HL:  sp_next = hl;
                OP_HL_SPE:
                begin
                    {regs_next[4], regs_next[5]} = sum16;
                    flags_next = {2'b00, sum_nib[4], sum_byte[8]};
                end
                OP_ST_SP:
                begin
                    kind = ACC_WRITE; addr = imm16; data = sp_reg[7:0];
                    two_results = 1'b1;
                end
                default: kind = ACC_NONE;
            endcase
        end

        res_first.kind    = kind;
        res_first.addr    = addr;
        res_first.data    = data;
        res_first.last    = ~two_results;
        res_first.accum   = regs_next[6];
        res_first.pointer = {regs_next[4], regs_next[5]};
        res_first.stack   = sp_next;
        res_first.flags   = flags_next;
        res_second        = res_first;
        res_second.addr   = imm16 + 16'd1;
        res_second.data   = sp_reg[15:8];
        res_second.last   = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                regs_reg[i] <= '0;
            end
            sp_reg    <= '0;
            flags_reg <= '0;
            pend_reg  <= 1'b0;
            dest_reg  <= '0;
        end
        else if (step)
        begin
            regs_reg  <= regs_next;
            sp_reg    <= sp_next;
            flags_reg <= flags_next;
            pend_reg  <= pend_next;
            dest_reg  <= dest_next;
        end
    end

endmodule

// ===== design/cpu_load_move_unit_top.sv =====
// Top level of the load/move unit: input register, execution core, result buffer.
// Depends on clmu_pkg and clmu_exec.
//
//  channel | handshake                 | payload
//  in      | in_valid / in_ready       | cmd, opcode, imm_low, imm_high, read_data
//  out     | out_valid / out_ready     | access_kind .. flag_bits
//
// An item is registered on acceptance and executed once the result buffer has room;
// its result is then registered into the buffer. One item per cycle is sustained
// while the buffer has room; LD (a16),SP yields two results. A four-entry result
// buffer decouples the sides, so input stalls only when it cannot take what is in flight.
// Reset clears the valid flag, execution state, buffer pointers and count, not data.
module cpu_load_move_unit_top
    import clmu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  opcode,
    input  logic [7:0]  imm_low,
    input  logic [7:0]  imm_high,
    input  logic [7:0]  read_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  access_kind,
    output logic [15:0] access_address,
    output logic [7:0]  write_byte,
    output logic        last,
    output logic [7:0]  accum_value,
    output logic [15:0] pointer_value,
    output logic [15:0] stack_value,
    output logic [3:0]  flag_bits
);

    logic       iv_reg;
    logic       cmd_reg;
    logic [7:0] op_reg, lo_reg, hi_reg, rd_reg;
    result_t    r0, r1;
    logic       two;
    result_t    buf_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       step, pop;
    logic [2:0] need;

    // Execute when the buffer has room for whatever this item produces.
    assign need = two ? 3'd2 : 3'd1;
    assign pop  = out_valid && out_ready;
    assign step = iv_reg && ({1'b0, cnt_reg} + 4'd0 + {1'b0, need} <= 4'd4);
    assign in_ready = !iv_reg || step;

    clmu_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .cmd         (cmd_reg),
        .opcode      (op_reg),
        .imm_low     (lo_reg),
        .imm_high    (hi_reg),
        .read_data   (rd_reg),
        .res_first   (r0),
        .res_second  (r1),
        .two_results (two)
    );

    always_comb
    begin
        cnt_next = cnt_reg - (pop ? 3'd1 : 3'd0) + (step ? need : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg  <= 1'b0;
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                iv_reg <= in_valid;
            end
            if (step)
            begin
                wp_reg <= wp_reg + (two ? 2'd2 : 2'd1);
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cmd_reg <= cmd;
            op_reg  <= opcode;
            lo_reg  <= imm_low;
            hi_reg  <= imm_high;
            rd_reg  <= read_data;
        end
        if (step)
        begin
            buf_reg[wp_reg] <= r0;
            if (two)
            begin
                buf_reg[wp_reg + 2'd1] <= r1;
            end
        end
    end

    assign out_valid      = cnt_reg != 3'd0;
    assign access_kind    = buf_reg[rp_reg].kind;
    assign access_address = buf_reg[rp_reg].addr;
    assign write_byte     = buf_reg[rp_reg].data;
    assign last           = buf_reg[rp_reg].last;
    assign accum_value    = buf_reg[rp_reg].accum;
    assign pointer_value  = buf_reg[rp_reg].pointer;
    assign stack_value    = buf_reg[rp_reg].stack;
    assign flag_bits      = buf_reg[rp_reg].flags;

endmodule

// ===== design/clmu_checker.sv =====
// Port-level checker for the load/move unit, bound to the top level.
// Depends on clmu_pkg.
module clmu_port_props
    import clmu_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  access_kind,
    input logic [15:0] access_address,
    input logic [7:0]  write_byte,
    input logic        last,
    input logic [3:0]  flag_bits
);

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (access_kind == ACC_NONE || access_kind == ACC_READ ||
                       access_kind == ACC_WRITE))
        else $error("illegal access kind");

    a_no_access_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && access_kind == ACC_NONE |-> access_address == 16'd0 && write_byte == 8'd0)
        else $error("idle result carries an address or data");

    a_flags_zn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flag_bits[3:2] == 2'b00)
        else $error("Z or N flag set");

    a_second_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && last && access_kind == ACC_WRITE
                                         && access_address == $past(access_address) + 16'd1)
        else $error("second write of a two-byte store is wrong");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(access_address))
        else $error("stalled result changed");

endmodule

bind cpu_load_move_unit_top clmu_port_props u_clmu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .access_kind    (access_kind),
    .access_address (access_address),
    .write_byte     (write_byte),
    .last           (last),
    .flag_bits      (flag_bits)
);

// ===== tb/sv/clmu_checker.sv =====
// Checker for the load/move unit: watches both channels, predicts results, compares.
// Depends on clmu_pkg; instantiated beside the block by tb.
module clmu_checker
    import clmu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cmd,
    input  logic [7:0]  opcode,
    input  logic [7:0]  imm_low,
    input  logic [7:0]  imm_high,
    input  logic [7:0]  read_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  access_kind,
    input  logic [15:0] access_address,
    input  logic [7:0]  write_byte,
    input  logic        last,
    input  logic [7:0]  accum_value,
    input  logic [15:0] pointer_value,
    input  logic [15:0] stack_value,
    input  logic [3:0]  flag_bits,
    output int          fail_count,
    output int          pending_count
);

    // Register file order: B, C, D, E, H, L, A.
    logic [7:0]  regs [7];
    logic [15:0] sp;
    logic [3:0]  zf;
    logic        load_wait;
    logic [2:0]  load_dest;
    result_t     expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int slot_of(logic [2:0] code);
        if (code == RCODE_A) return 6;
        if (code == RCODE_MEM) return -1;
        return int'(code);
    endfunction

    function automatic logic [7:0] reg_rd(logic [2:0] code);
        int s;
        s = slot_of(code);
        return (s < 0) ? 8'h00 : regs[s];
    endfunction

    task automatic reg_wr(logic [2:0] code, logic [7:0] v);
        int s;
        s = slot_of(code);
        if (s >= 0) regs[s] = v;
    endtask

    task automatic push_result(logic [1:0] k, logic [15:0] a, logic [7:0] d, logic l);
        result_t r;
        r.kind = k; r.addr = a; r.data = d; r.last = l;
        r.accum = regs[6]; r.pointer = {regs[4], regs[5]};
        r.stack = sp; r.flags = zf;
        expected_results.push_back(r);
    endtask

    task automatic start_read(logic [15:0] a, logic [2:0] dest,
                              ref logic [1:0] k, ref logic [15:0] ad);
        load_wait = 1'b1; load_dest = dest; k = ACC_READ; ad = a;
    endtask

    task automatic execute_item(logic c, logic [7:0] op, logic [7:0] lo,
                                logic [7:0] hi, logic [7:0] rd);
        logic [1:0]  k;
        logic [15:0] a;
        logic [7:0]  d;
        logic [15:0] hl;
        logic [15:0] imm;
        logic [15:0] sum;
        logic [4:0]  nib;
        logic [8:0]  byt;
        k = ACC_NONE; a = '0; d = '0; imm = {hi, lo};
        if (c == CMD_RDATA) begin
            if (load_wait) begin
                reg_wr(load_dest, rd);
                load_wait = 1'b0;
            end
            push_result(ACC_NONE, '0, '0, 1'b1);
            return;
        end
        load_wait = 1'b0;
        hl = {regs[4], regs[5]};
        if (op >= 8'h40 && op <= 8'h7F) begin
            if (op == OP_HALT) begin
            end else if (op[2:0] == RCODE_MEM) begin
                start_read(hl, op[5:3], k, a);
            end else if (op[5:3] == RCODE_MEM) begin
                k = ACC_WRITE; a = hl; d = reg_rd(op[2:0]);
            end else begin
                reg_wr(op[5:3], reg_rd(op[2:0]));
            end
        end else begin
            case (op)
                OP_LD_BC: {regs[0], regs[1]} = imm;
                OP_LD_DE: {regs[2], regs[3]} = imm;
                OP_LD_HL: {regs[4], regs[5]} = imm;
                OP_LD_SP: sp = imm;
                OP_LD_B_N, OP_LD_C_N, OP_LD_D_N, OP_LD_E_N,
                OP_LD_H_N, OP_LD_L_N, OP_LD_A_N: reg_wr(op[5:3], lo);
                OP_ST_HL_N: begin k = ACC_WRITE; a = hl; d = lo; end
                OP_ST_BC: begin k = ACC_WRITE; a = {regs[0], regs[1]}; d = regs[6]; end
                OP_ST_DE: begin k = ACC_WRITE; a = {regs[2], regs[3]}; d = regs[6]; end
                OP_ST_HLI: begin
                    k = ACC_WRITE; a = hl; d = regs[6]; {regs[4], regs[5]} = hl + 16'd1;
                end
                OP_ST_HLD: begin
                    k = ACC_WRITE; a = hl; d = regs[6]; {regs[4], regs[5]} = hl - 16'd1;
                end
                OP_LD_BC_M: start_read({regs[0], regs[1]}, RCODE_A, k, a);
                OP_LD_DE_M: start_read({regs[2], regs[3]}, RCODE_A, k, a);
                OP_LD_HLI: begin
                    start_read(hl, RCODE_A, k, a); {regs[4], regs[5]} = hl + 16'd1;
                end
                OP_LD_HLD: begin
                    start_read(hl, RCODE_A, k, a); {regs[4], regs[5]} = hl - 16'd1;
                end
                OP_STH_N: begin k = ACC_WRITE; a = HIGH_PAGE + lo; d = regs[6]; end
                OP_LDH_N: start_read(HIGH_PAGE + lo, RCODE_A, k, a);
                OP_STH_C: begin k = ACC_WRITE; a = HIGH_PAGE + regs[1]; d = regs[6]; end
                OP_LDH_C: start_read(HIGH_PAGE + regs[1], RCODE_A, k, a);
                OP_ST_ABS: begin k = ACC_WRITE; a = imm; d = regs[6]; end
                OP_LD_ABS: start_read(imm, RCODE_A, k, a);
                OP_SP_HL: sp = hl;
                OP_HL_SPE: begin
                    sum = sp + {{8{lo[7]}}, lo};
                    nib = {1'b0, sp[3:0]} + {1'b0, lo[3:0]};
                    byt = {1'b0, sp[7:0]} + {1'b0, lo};
                    {regs[4], regs[5]} = sum;
                    zf = {2'b00, nib[4], byt[8]};
                end
                OP_ST_SP: begin
                    push_result(ACC_WRITE, imm, sp[7:0], 1'b0);
                    push_result(ACC_WRITE, imm + 16'd1, sp[15:8], 1'b1);
                    return;
                end
                default: ;
            endcase
        end
        push_result(k, a, d, 1'b1);
    endtask

    task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t e;
        if (!rst_n) begin
            foreach (regs[i]) regs[i] = '0;
            sp = '0; zf = '0; load_wait = 1'b0; load_dest = '0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (in_valid && in_ready)
                execute_item(cmd, opcode, imm_low, imm_high, read_data);
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, kind %h addr %h",
                             $time, access_kind, access_address);
                end else begin
                    e = expected_results.pop_front();
                    compare_field("access_kind", 16'(e.kind), 16'(access_kind));
                    compare_field("access_address", e.addr, access_address);
                    compare_field("write_byte", 16'(e.data), 16'(write_byte));
                    compare_field("last", 16'(e.last), 16'(last));
                    compare_field("accum_value", 16'(e.accum), 16'(accum_value));
                    compare_field("pointer_value", e.pointer, pointer_value);
                    compare_field("stack_value", e.stack, stack_value);
                    compare_field("flag_bits", 16'(e.flags), 16'(flag_bits));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the load/move unit: clock, reset, stimulus, idling and verdict.
// Depends on clmu_pkg, clmu_checker and cpu_load_move_unit_top.
module tb;
    import clmu_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 650;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        cmd = CMD_INSTR;
    logic [7:0]  opcode = '0;
    logic [7:0]  imm_low = '0;
    logic [7:0]  imm_high = '0;
    logic [7:0]  read_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  access_kind;
    logic [15:0] access_address;
    logic [7:0]  write_byte;
    logic        last;
    logic [7:0]  accum_value;
    logic [15:0] pointer_value;
    logic [15:0] stack_value;
    logic [3:0]  flag_bits;
    int          fail_count;
    int          pending_count;
    bit          hold_off = 1'b0;
    bit          sending_done = 1'b0;
    int          quiet_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cpu_load_move_unit_top u_top (.*);
    clmu_checker u_checker (.*);

    // Offer one item, hold it until accepted, then drop valid for a random gap unless no_gap.
    task automatic send_item(logic c, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                             logic [7:0] rd, bit no_gap);
        int gap;
        cmd <= c; opcode <= op; imm_low <= lo; imm_high <= hi; read_data <= rd;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_instr(logic [7:0] op, bit no_gap);
        send_item(CMD_INSTR, op, 8'($urandom), 8'($urandom), 8'($urandom), no_gap);
    endtask

    // Register moves, common load-group opcodes or a random byte, so most random items do useful work.
    function automatic logic [7:0] pick_load_op();
        logic [7:0] ops [30] = '{OP_LD_BC, OP_LD_DE, OP_LD_HL, OP_LD_SP, OP_LD_B_N,
            OP_LD_C_N, OP_LD_D_N, OP_LD_E_N, OP_LD_H_N, OP_LD_L_N, OP_LD_A_N,
            OP_ST_HL_N, OP_ST_BC, OP_ST_DE, OP_ST_HLI, OP_ST_HLD, OP_LD_BC_M,
            OP_LD_DE_M, OP_LD_HLI, OP_LD_HLD, OP_STH_N, OP_LDH_N, OP_STH_C,
            OP_LDH_C, OP_ST_ABS, OP_LD_ABS, OP_SP_HL, OP_HL_SPE, OP_ST_SP, OP_HALT};
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'h40 + 8'($urandom_range(0, 63));
        if (r < 9) return ops[$urandom_range(0, 29)];
        return 8'($urandom);
    endfunction

    initial begin
        logic [7:0] op;
        bit burst;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed part: loads with edge values, address forms other than DE, SP tricks.
        send_item(CMD_INSTR, OP_LD_SP, 8'hFF, 8'hFF, 8'h00, 0);
        send_item(CMD_INSTR, OP_HL_SPE, 8'h01, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_LD_SP, 8'h08, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_HL_SPE, 8'h80, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_HL_SPE, 8'h7F, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_ST_SP, 8'hFF, 8'hFF, 8'h00, 0);
        send_item(CMD_INSTR, OP_LD_HL, 8'hFF, 8'hFF, 8'h00, 0);
        send_item(CMD_INSTR, OP_LD_HLI, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_RDATA, 8'h00, 8'h00, 8'h00, 8'hFF, 0);
        send_item(CMD_INSTR, OP_LD_HLD, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_RDATA, 8'hFF, 8'hFF, 8'hFF, 8'h5A, 0);
        send_item(CMD_RDATA, 8'h00, 8'h00, 8'h00, 8'hA5, 0);
        send_item(CMD_INSTR, 8'h46, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_ST_BC, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_LD_C_N, 8'hFF, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_STH_C, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_LDH_N, 8'hFF, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_LD_ABS, 8'h34, 8'h12, 8'h00, 0);
        send_item(CMD_RDATA, 8'h00, 8'h00, 8'h00, 8'h77, 0);
        send_item(CMD_INSTR, OP_ST_HLI, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, OP_HALT, 8'h00, 8'h00, 8'h00, 0);
        send_item(CMD_INSTR, 8'hCB, 8'hFF, 8'hFF, 8'hFF, 0);
        send_item(CMD_INSTR, OP_SP_HL, 8'h00, 8'h00, 8'h00, 0);
        // Random part: mostly instructions, each usually followed by a read-data item.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            burst = (i % 200) < 40;
            if ($urandom_range(0, 9) == 0) begin
                send_item(CMD_RDATA, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), burst);
            end else begin
                op = pick_load_op();
                send_instr(op, burst);
                if ($urandom_range(0, 3) != 0)
                    send_item(CMD_RDATA, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), burst);
            end
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls per item, plus one long hold-off while items keep coming.
    initial begin
        int wait_cycles;
        @(posedge rst_n);
        repeat (60) @(posedge clk);
        hold_off = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (wait_cycles > 0) begin
                out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        wait (sending_done);
        // Let the checker record the last accepted item before the queue is polled.
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
